[hw/rtl/button_debounce_autorepeat_unit_defines.svh]
// ----------------------------------------------------------------------------
// Button debounce / auto-repeat assertion macros
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_AUTOREPEAT_UNIT_DEFINES_SVH
`define BUTTON_DEBOUNCE_AUTOREPEAT_UNIT_DEFINES_SVH

// same-cycle implication
`define BDAR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BDAR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/bdar_pkg.sv]
// ----------------------------------------------------------------------------
// bdar_pkg
// Types and constants shared by the button debounce / auto-repeat unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bdar_pkg;

    localparam int BUTTONS_DEF = 8;
    localparam int RAW_W       = 8;
    localparam int TIME_W      = 32;
    localparam int ROOM_W      = 4;
    localparam int BTN_W       = 3;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE     = 2'd2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd20;
    localparam logic [CFG_W-1:0] DELAY_RST    = 16'd400;
    localparam logic [CFG_W-1:0] RATE_RST     = 16'd60;

    typedef struct packed {
        logic [RAW_W-1:0]  raw_pressed;
        logic [TIME_W-1:0] now_ms;
        logic [ROOM_W-1:0] room;
    } poll_t;

    typedef struct packed {
        logic [BTN_W-1:0] button_index;
        logic             is_repeat;
        logic             last_event;
    } result_t;

    // scan record between front and back
    typedef struct packed {
        logic [BTN_W-1:0] button;
        logic             repeat_ev;
        logic             is_event;
        logic             poll_end;
    } rec_t;

endpackage

`default_nettype wire

[hw/rtl/button_debounce_autorepeat_unit.sv]
// ----------------------------------------------------------------------------
// button_debounce_autorepeat_unit
// Debounces up to eight buttons and emits press and auto-repeat words.
//
//   channel  dir  handshake          payload
//   poll     in   push / full        poll_t   (raw_pressed, now_ms, room)
//   result   out  pop / empty        result_t (button_index, is_repeat, last_event)
//   cfg      in   cfg_we             cfg_index, cfg_data
//
// A poll is scanned one button per cycle while the queue has room, by the
// single scan datapath. The next poll is taken in the last scan cycle.
// Words leave at most one per cycle through a 4-entry queue, a one-word hold
// stage and a result register.
// A stalled result side backs up the queue and then holds the scan.
// rst_n clears all levels, the repeat owner and the registers to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_autorepeat_unit
    import bdar_pkg::*;
#(
    parameter int BUTTONS = BUTTONS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 push,
    output logic                      full,
    input  wire poll_t                poll,
    input  wire logic                 pop,
    output logic                      empty,
    output result_t                   result
);

    logic q_push, q_full, q_pop, q_empty;
    rec_t q_wr_rec, q_rd_rec;

    bdar_front #(
        .BUTTONS (BUTTONS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .poll      (poll),
        .q_push    (q_push),
        .q_rec     (q_wr_rec),
        .q_full    (q_full)
    );

    bdar_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_rec  (q_wr_rec),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_rec  (q_rd_rec),
        .q_empty (q_empty)
    );

    bdar_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_rec   (q_rd_rec),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

`default_nettype wire

[hw/rtl/bdar_front.sv]
// ----------------------------------------------------------------------------
// bdar_front
// Takes polls, scans one button per cycle while the queue has room, applies
// debounce and repeat rules and queues a record per kept event and poll end.
// ----------------------------------------------------------------------------
`default_nettype none

module bdar_front
    import bdar_pkg::*;
#(
    parameter int BUTTONS = BUTTONS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 push,
    output logic                      full,
    input  wire poll_t                poll,
    output logic                      q_push,
    output rec_t                      q_rec,
    input  wire logic                 q_full
);

    localparam int CW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
    localparam logic [CW-1:0] LAST_IDX = CW'(BUTTONS - 1);

    logic [CFG_W-1:0]   debounce_reg;
    logic [CFG_W-1:0]   delay_reg;
    logic [CFG_W-1:0]   rate_reg;

    logic               busy_reg;
    logic [CW-1:0]      idx_reg;
    logic [ROOM_W-1:0]  count_reg;
    logic [BUTTONS-1:0] raw_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [TIME_W-1:0]  due_press_reg;
    logic [TIME_W-1:0]  due_rep_reg;
    logic [ROOM_W-1:0]  room_reg;

    logic [BUTTONS-1:0] stable_reg, stable_next;
    logic [BUTTONS-1:0] prev_reg, prev_next;
    logic [TIME_W-1:0]  ct_reg [BUTTONS];
    logic               rep_active_reg, rep_active_next;
    logic [CW-1:0]      rep_btn_reg, rep_btn_next;
    logic [TIME_W-1:0]  rep_due_reg;

    logic               accept, step, last_step;
    logic               down, was, st, owner, deb_ok, rep_ok;
    logic [TIME_W-1:0]  d_db, d_rp;
    logic               ct_we, due_we, has_kind, kind_rep, emit;
    logic [TIME_W-1:0]  due_new;

    assign step      = busy_reg && !q_full;
    assign last_step = (idx_reg == LAST_IDX);
    assign full      = busy_reg && !(step && last_step);
    assign accept    = push && !full;

    assign down   = raw_reg[idx_reg];
    assign was    = prev_reg[idx_reg];
    assign st     = stable_reg[idx_reg];
    assign owner  = rep_active_reg && (rep_btn_reg == idx_reg);
    assign d_db   = now_reg - ct_reg[idx_reg];
    assign d_rp   = now_reg - rep_due_reg;
    assign deb_ok = !d_db[TIME_W-1] && (d_db >= {{(TIME_W-CFG_W){1'b0}}, debounce_reg});
    assign rep_ok = !d_rp[TIME_W-1];

    always_comb
    begin
        stable_next     = stable_reg;
        prev_next       = prev_reg;
        rep_active_next = rep_active_reg;
        rep_btn_next    = rep_btn_reg;
        ct_we           = 1'b0;
        due_we          = 1'b0;
        due_new         = due_press_reg;
        has_kind        = 1'b0;
        kind_rep        = 1'b0;
        prev_next[idx_reg] = down;
        if (down != was)
        begin
            ct_we = 1'b1;
        end
        else if ((down != st) && deb_ok)
        begin
            stable_next[idx_reg] = down;
            if (down)
            begin
                has_kind        = 1'b1;
                rep_active_next = 1'b1;
                rep_btn_next    = idx_reg;
                due_we          = 1'b1;
            end
            else if (owner)
            begin
                rep_active_next = 1'b0;
            end
        end
        else if (down && st && owner && rep_ok)
        begin
            has_kind = 1'b1;
            kind_rep = 1'b1;
            due_we   = 1'b1;
            due_new  = due_rep_reg;
        end
    end

    assign emit   = has_kind && (count_reg < room_reg);
    assign q_push = step && (emit || last_step);

    always_comb
    begin
        q_rec           = '0;
        q_rec.button    = BTN_W'(idx_reg);
        q_rec.repeat_ev = kind_rep;
        q_rec.is_event  = emit;
        q_rec.poll_end  = last_step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RST;
            delay_reg    <= DELAY_RST;
            rate_reg     <= RATE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE: debounce_reg <= cfg_data;
                REG_DELAY:    delay_reg    <= cfg_data;
                REG_RATE:     rate_reg     <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            idx_reg        <= '0;
            count_reg      <= '0;
            stable_reg     <= '0;
            prev_reg       <= '0;
            rep_active_reg <= 1'b0;
            rep_btn_reg    <= '0;
        end
        else
        begin
            if (step)
            begin
                stable_reg     <= stable_next;
                prev_reg       <= prev_next;
                rep_active_reg <= rep_active_next;
                rep_btn_reg    <= rep_btn_next;
            end
            if (accept)
            begin
                busy_reg  <= 1'b1;
                idx_reg   <= '0;
                count_reg <= '0;
            end
            else if (step)
            begin
                idx_reg <= idx_reg + CW'(1);
                if (emit)
                    count_reg <= count_reg + ROOM_W'(1);
                if (last_step)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            raw_reg       <= poll.raw_pressed[BUTTONS-1:0];
            now_reg       <= poll.now_ms;
            room_reg      <= poll.room;
            due_press_reg <= poll.now_ms + {{(TIME_W-CFG_W){1'b0}}, delay_reg};
            due_rep_reg   <= poll.now_ms + {{(TIME_W-CFG_W){1'b0}}, rate_reg};
        end
        if (step && ct_we)
            ct_reg[idx_reg] <= now_reg;
        if (step && due_we)
            rep_due_reg <= due_new;
    end

endmodule

`default_nettype wire

[hw/rtl/bdar_fifo.sv]
// ----------------------------------------------------------------------------
// bdar_fifo
// Short record queue between the scan front and the output back.
// ----------------------------------------------------------------------------
`default_nettype none

module bdar_fifo
    import bdar_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire rec_t wr_rec,
    output logic      q_full,
    input  wire logic rd_en,
    output rec_t      rd_rec,
    output logic      q_empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    rec_t            slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [NW-1:0]   cnt_reg;
    logic            do_wr, do_rd;

    assign q_full  = (cnt_reg == NW'(QUEUE_DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_rec  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + NW'(1);
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - NW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_rec;
    end

endmodule

`default_nettype wire

[hw/rtl/bdar_back.sv]
// ----------------------------------------------------------------------------
// bdar_back
// Holds one event back until its own record or the next one shows whether
// it ends the poll, tags the last word and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bdar_back
    import bdar_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_empty,
    input  wire rec_t q_rec,
    output logic      q_pop,
    output logic      empty,
    input  wire logic pop,
    output result_t   result
);

    logic             pend_valid_reg, pend_valid_next;
    logic             pend_end_reg, pend_end_next;
    logic [BTN_W-1:0] pend_btn_reg, pend_btn_next;
    logic             pend_rep_reg, pend_rep_next;
    logic             out_valid_reg;
    result_t          out_reg;
    logic             out_free, load_out, load_last;

    assign out_free = !out_valid_reg || pop;

    always_comb
    begin
        q_pop           = 1'b0;
        load_out        = 1'b0;
        load_last       = 1'b0;
        pend_valid_next = pend_valid_reg;
        pend_end_next   = pend_end_reg;
        pend_btn_next   = pend_btn_reg;
        pend_rep_next   = pend_rep_reg;
        if (pend_valid_reg && pend_end_reg)
        begin
            if (out_free)
            begin
                load_out        = 1'b1;
                load_last       = 1'b1;
                pend_valid_next = 1'b0;
            end
        end
        else if (!q_empty)
        begin
            if (q_rec.is_event)
            begin
                if (!pend_valid_reg || out_free)
                begin
                    load_out        = pend_valid_reg;
                    q_pop           = 1'b1;
                    pend_valid_next = 1'b1;
                    pend_end_next   = q_rec.poll_end;
                    pend_btn_next   = q_rec.button;
                    pend_rep_next   = q_rec.repeat_ev;
                end
            end
            else if (!pend_valid_reg)
            begin
                q_pop = 1'b1;
            end
            else if (out_free)
            begin
                q_pop           = 1'b1;
                load_out        = 1'b1;
                load_last       = 1'b1;
                pend_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_end_reg <= pend_end_next;
        pend_btn_reg <= pend_btn_next;
        pend_rep_reg <= pend_rep_next;
        if (load_out)
        begin
            out_reg.button_index <= pend_btn_reg;
            out_reg.is_repeat    <= pend_rep_reg;
            out_reg.last_event   <= load_last;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

endmodule

`default_nettype wire

[hw/rtl/bdar_checker.sv]
// ----------------------------------------------------------------------------
// bdar_checker
// Port-level checks for the button debounce / auto-repeat unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_debounce_autorepeat_unit_defines.svh"

module bdar_checker
    import bdar_pkg::*;
#(
    parameter int BUTTONS = BUTTONS_DEF
)
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    push,
    input wire logic    full,
    input wire poll_t   poll,
    input wire logic    pop,
    input wire logic    empty,
    input wire result_t result
);

    logic multi_btn;
    logic poll_taken;

    assign multi_btn  = (BUTTONS > 1);
    assign poll_taken = push && !full && (poll.room == poll.room);

    `BDAR_ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(result), "result word changed while stalled")
    `BDAR_ASSERT_NOW(a_index_range, !empty, int'(result.button_index) < BUTTONS, "button index out of range")
    `BDAR_ASSERT_NEXT(a_scan_busy, multi_btn && poll_taken, full, "scan not busy after poll accepted")

endmodule

bind button_debounce_autorepeat_unit bdar_checker #(
    .BUTTONS (BUTTONS)
) u_bdar_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .poll   (poll),
    .pop    (pop),
    .empty  (empty),
    .result (result)
);

`default_nettype wire

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: button debounce / auto-repeat unit testbench
// Feeds polls through the push/full side and pulls event words through
// pop/empty. A directed table comes first: press, repeat, dropped words when
// room runs out, time wrap, a negative time difference, and zero debounce and
// zero rate. Random polls follow under several register settings, extremes
// included. Words are checked against an in-bench scan or a typed table row.
// ----------------------------------------------------------------------------
module tb_top;
    import bdar_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES  = 32;
    localparam int HOLD_AT        = 60;
    localparam int HOLD_CYCLES    = 400;
    localparam int RAND_PER_PHASE = 68;
    localparam int PHASES         = 6;
    localparam int PLAN_LEN       = 28;

    localparam result_t NO_WORD = '0;
    localparam poll_t   NO_POLL = '0;

    localparam int PH_DEB  [5] = '{5, 0, 65535, 2, 1};
    localparam int PH_DLY  [5] = '{30, 0, 65535, 65535, 5};
    localparam int PH_RATE [5] = '{7, 0, 65535, 1, 65535};

    typedef enum logic {ROW_POLL, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_W-1:0]      reg_val;
        poll_t                 p;
        bit                    typed;
        int                    n_exp;
        result_t               w;
    } row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 push;
    logic                 full;
    poll_t                poll;
    logic                 pop;
    logic                 empty;
    result_t              result;

    // scan state mirror
    logic [CFG_W-1:0]  deb_ms;
    logic [CFG_W-1:0]  delay_ms;
    logic [CFG_W-1:0]  rate_ms;
    logic [RAW_W-1:0]  stable_lv;
    logic [RAW_W-1:0]  prev_raw;
    logic [TIME_W-1:0] change_at [BUTTONS_DEF];
    bit                owner_on;
    logic [BTN_W-1:0]  owner;
    logic [TIME_W-1:0] due_ms;

    result_t pending_words [$];
    int      bad_words;
    int      polls_done;
    bit      held_off;

    row_t plan [PLAN_LEN] = '{
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, '{8'h00, 32'd0, 4'd8}, 1'b1, 0, NO_WORD},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, '{8'h01, 32'd100, 4'd8}, 1'b1, 0, NO_WORD},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, '{8'h01, 32'd119, 4'd8}, 1'b1, 0, NO_WORD},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, '{8'h01, 32'd120, 4'd8}, 1'b1, 1,
          '{3'd0, 1'b0, 1'b1}},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, '{8'h01, 32'd520, 4'd8}, 1'b1, 1,
          '{3'd0, 1'b1, 1'b1}},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, '{8'h81, 32'd530, 4'd8}, 1'b0, 0, NO_WORD},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, '{8'h81, 32'd550, 4'd0}, 1'b1, 0, NO_WORD},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, '{8'h81, 32'd950, 4'd15}, 1'b1, 1,
          '{3'd7, 1'b1, 1'b1}},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, '{8'hFF, 32'd960, 4'd15}, 1'b0, 0, NO_WORD},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, '{8'hFF, 32'd980, 4'd3}, 1'b0, 0, NO_WORD},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, '{8'hFF, 32'd1380, 4'd8}, 1'b0, 0, NO_WORD},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, '{8'h7F, 32'd1390, 4'd8}, 1'b0, 0, NO_WORD},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, '{8'h00, 32'd1400, 4'd8}, 1'b0, 0, NO_WORD},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, '{8'h00, 32'd1420, 4'd8}, 1'b1, 0, NO_WORD},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, '{8'h10, 32'hFFFF_FFF0, 4'd8}, 1'b1, 0, NO_WORD},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, '{8'h10, 32'd4, 4'd8}, 1'b1, 1,
          '{3'd4, 1'b0, 1'b1}},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, '{8'h10, 32'h9000_0000, 4'd8}, 1'b1, 0, NO_WORD},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, '{8'h10, 32'hFFFF_FFFF, 4'd8}, 1'b0, 0, NO_WORD},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, '{8'h10, 32'd404, 4'd8}, 1'b1, 1,
          '{3'd4, 1'b1, 1'b1}},
        '{ROW_CFG, REG_RATE, 16'd0, NO_POLL, 1'b0, 0, NO_WORD},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, '{8'h10, 32'd464, 4'd8}, 1'b1, 1,
          '{3'd4, 1'b1, 1'b1}},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, '{8'h10, 32'd464, 4'd8}, 1'b1, 1,
          '{3'd4, 1'b1, 1'b1}},
        '{ROW_CFG, REG_DEBOUNCE, 16'd0, NO_POLL, 1'b0, 0, NO_WORD},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, '{8'h00, 32'd470, 4'd8}, 1'b0, 0, NO_WORD},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, '{8'h00, 32'd470, 4'd8}, 1'b0, 0, NO_WORD},
        '{ROW_CFG, REG_DELAY, 16'hFFFF, NO_POLL, 1'b0, 0, NO_WORD},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, '{8'h01, 32'd480, 4'd15}, 1'b0, 0, NO_WORD},
        '{ROW_POLL, REG_DEBOUNCE, 16'd0, '{8'h01, 32'd480, 4'd15}, 1'b1, 1,
          '{3'd0, 1'b0, 1'b1}}
    };

    button_debounce_autorepeat_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .poll      (poll),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    // signed 32-bit "a - b >= lim" on wrapping times
    function automatic bit held_for(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b,
                                    input logic [TIME_W-1:0] lim);
        logic [TIME_W-1:0] d;
        d = a - b;
        return !d[TIME_W-1] && d >= lim;
    endfunction

    function automatic int scan_poll(input poll_t p, output result_t ev [BUTTONS_DEF]);
        logic [TIME_W-1:0] now;
        int                n;
        bit                down;
        bit                was;
        bit                st;
        bit                fire;
        bit                rep;
        now = p.now_ms;
        n = 0;
        foreach (ev[k])
            ev[k] = NO_WORD;
        for (int i = 0; i < BUTTONS_DEF; i++)
        begin
            down = p.raw_pressed[i];
            was  = prev_raw[i];
            st   = stable_lv[i];
            fire = 1'b0;
            rep  = 1'b0;
            if (down != was)
                change_at[i] = now;
            else if (down != st && held_for(now, change_at[i], TIME_W'(deb_ms)))
            begin
                stable_lv[i] = down;
                if (down)
                begin
                    fire     = 1'b1;
                    owner_on = 1'b1;
                    owner    = BTN_W'(i);
                    due_ms   = now + TIME_W'(delay_ms);
                end
                else if (owner_on && owner == BTN_W'(i))
                    owner_on = 1'b0;
            end
            else if (down && st && owner_on && owner == BTN_W'(i) && held_for(now, due_ms, '0))
            begin
                fire   = 1'b1;
                rep    = 1'b1;
                due_ms = now + TIME_W'(rate_ms);
            end
            if (fire && n < int'(p.room))
            begin
                ev[n] = '{BTN_W'(i), rep, 1'b0};
                n++;
            end
        end
        prev_raw = p.raw_pressed;
        if (n > 0)
            ev[n-1].last_event = 1'b1;
        return n;
    endfunction

    function automatic int idle_len(inout int calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if (r < 4)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    int calm_tx = 0;

    task automatic offer_poll(input poll_t p, input bit typed, input int n_typed,
                              input result_t typed_w);
        result_t ev [BUTTONS_DEF];
        int      n;
        int      g;
        g = idle_len(calm_tx);
        if (g > 0)
        begin
            push <= 1'b0;
            repeat (g) @(posedge clk);
        end
        push <= 1'b1;
        poll <= p;
        do @(posedge clk); while (full);
        n = scan_poll(p, ev);
        if (typed)
        begin
            n = n_typed;
            ev[0] = typed_w;
        end
        for (int k = 0; k < n; k++)
            pending_words.push_back(ev[k]);
        polls_done++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        push <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_DEBOUNCE: deb_ms   = val;
            REG_DELAY:    delay_ms = val;
            REG_RATE:     rate_ms  = val;
            default:      ;
        endcase
    endtask

    initial
    begin : stim
        logic [RAW_W-1:0]  held;
        logic [RAW_W-1:0]  raw;
        logic [TIME_W-1:0] clock_ms;
        logic [ROOM_W-1:0] room;
        int                unit;
        int                r;
        int                b;
        int                d;
        int                dl;
        int                rt;
        rst_n     <= 1'b0;
        push      <= 1'b0;
        poll      <= NO_POLL;
        cfg_we    <= 1'b0;
        cfg_index <= REG_DEBOUNCE;
        cfg_data  <= '0;
        deb_ms    = DEBOUNCE_RST;
        delay_ms  = DELAY_RST;
        rate_ms   = RATE_RST;
        stable_lv = '0;
        prev_raw  = '0;
        foreach (change_at[k])
            change_at[k] = '0;
        owner_on   = 1'b0;
        owner      = '0;
        due_ms     = '0;
        bad_words  = 0;
        polls_done = 0;
        held_off   = 1'b0;
        held       = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[k])
        begin
            if (plan[k].kind == ROW_CFG)
                write_reg(plan[k].reg_idx, plan[k].reg_val);
            else
                offer_poll(plan[k].p, plan[k].typed, plan[k].n_exp, plan[k].w);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph < 5)
            begin
                d  = PH_DEB[ph];
                dl = PH_DLY[ph];
                rt = PH_RATE[ph];
            end
            else
            begin
                d  = $urandom_range(0, 40);
                dl = $urandom_range(0, 100);
                rt = $urandom_range(0, 20);
            end
            write_reg(REG_DEBOUNCE, CFG_W'(d));
            write_reg(REG_DELAY, CFG_W'(dl));
            write_reg(REG_RATE, CFG_W'(rt));
            unit = d;
            if (dl > unit)
                unit = dl;
            if (rt > unit)
                unit = rt;
            unit = unit / 3 + 2;
            clock_ms = $urandom;
            for (int k = 0; k < RAND_PER_PHASE; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 12)
                begin
                    b = $urandom_range(0, RAW_W - 1);
                    held[b] = ~held[b];
                end
                else if (r < 15)
                    held = RAW_W'($urandom);
                raw = held;
                if ($urandom_range(0, 99) < 8)
                    raw = RAW_W'($urandom);
                r = $urandom_range(0, 99);
                if (r < 4)
                    clock_ms += $urandom;
                else if (r >= 14)
                    clock_ms += TIME_W'($urandom_range(1, unit));
                if ($urandom_range(0, 99) < 70)
                    room = ROOM_W'($urandom_range(8, 15));
                else
                    room = ROOM_W'($urandom_range(0, 7));
                offer_poll('{raw, clock_ms, room}, 1'b0, 0, NO_WORD);
            end
        end

        push <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (bad_words == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin : drain
        result_t got;
        result_t want;
        int      g;
        int      calm_rx;
        calm_rx = 0;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            g = idle_len(calm_rx);
            if (!held_off && polls_done >= HOLD_AT)
            begin
                held_off = 1'b1;
                g = HOLD_CYCLES;
            end
            if (g > 0)
            begin
                pop <= 1'b0;
                repeat (g) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            got = result;
            if (pending_words.size() == 0)
            begin
                bad_words++;
                if (bad_words <= 10)
                    $display("unexpected word: btn=%0d rep=%0b last=%0b",
                             got.button_index, got.is_repeat, got.last_event);
            end
            else
            begin
                want = pending_words.pop_front();
                if (got.button_index !== want.button_index || got.is_repeat !== want.is_repeat
                    || got.last_event !== want.last_event)
                begin
                    bad_words++;
                    if (bad_words <= 10)
                        $display("word mismatch: exp btn=%0d rep=%0b last=%0b, got btn=%0d rep=%0b last=%0b",
                                 want.button_index, want.is_repeat, want.last_event,
                                 got.button_index, got.is_repeat, got.last_event);
                end
            end
        end
    end

endmodule
